@@ hdl/sia_pkg.sv @@
// Shared widths, codes and reset values of the safety interlock alert table.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package sia_pkg;

   localparam int ALERT_SLOTS_DEF = 8;

   localparam int KIND_W    = 4;
   localparam int DIST_W    = 13;
   localparam int GAS_W     = 12;
   localparam int BATT_W    = 15;
   localparam int AGE_W     = 32;
   localparam int CUR_W     = 16;
   localparam int ANGLE_W   = 12;
   localparam int SLOT_W    = 3;
   localparam int TYPE_W    = 3;
   localparam int LEVEL_W   = 2;
   localparam int ACTIVE_W  = 4;
   localparam int TOTAL_W   = 16;
   localparam int TILT_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [KIND_W-1:0] KIND_COLLISION = 4'd0;
   localparam logic [KIND_W-1:0] KIND_GAS       = 4'd1;
   localparam logic [KIND_W-1:0] KIND_BATTERY   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 4'd3;
   localparam logic [KIND_W-1:0] KIND_MOTOR     = 4'd4;
   localparam logic [KIND_W-1:0] KIND_TILT      = 4'd5;
   localparam logic [KIND_W-1:0] KIND_RESET_STOP = 4'd6;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd7;
   localparam logic [KIND_W-1:0] KIND_READ_SLOT = 4'd8;

   localparam logic [TYPE_W-1:0] TYPE_COLLISION   = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_GAS         = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_BATTERY     = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_OVERCURRENT = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_LINK        = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_TILT        = 3'd5;

   localparam logic [LEVEL_W-1:0] LVL_WARNING  = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd3;

   localparam logic [1:0] GRADE_PASS     = 2'd0;
   localparam logic [1:0] GRADE_WARNING  = 2'd1;
   localparam logic [1:0] GRADE_CRITICAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_DISTANCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DISTANCE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAS_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_CRIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEARTBEAT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LIMIT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LIMIT  = 3'd7;

   localparam logic [DIST_W-1:0] RST_SAFE_DISTANCE = 13'd300;
   localparam logic [DIST_W-1:0] RST_STOP_DISTANCE = 13'd150;
   localparam logic [GAS_W-1:0]  RST_GAS_LIMIT     = 12'd400;
   localparam logic [BATT_W-1:0] RST_BATTERY_LOW   = 15'd11100;
   localparam logic [BATT_W-1:0] RST_BATTERY_CRIT  = 15'd10500;
   localparam logic [CUR_W-1:0]  RST_HEARTBEAT     = 16'd2000;
   localparam logic [TILT_W-1:0] RST_TILT_LIMIT    = 11'd450;
   localparam logic [CUR_W-1:0]  RST_CURRENT_LIMIT = 16'd5000;

   localparam logic [GAS_W:0] GAS_CRIT_MARGIN = 13'd200;

endpackage

@@ hdl/sia_if.sv @@
// Valid/ready channel interfaces of the safety interlock: check request,
// status response and register write. Depend on sia_pkg for field widths.
`timescale 1ns / 1ps

interface sia_req_if;
   logic                                valid;
   logic                                ready;
   logic [sia_pkg::KIND_W-1:0]          kind;
   logic [sia_pkg::DIST_W-1:0]          front_distance;
   logic [sia_pkg::DIST_W-1:0]          rear_distance;
   logic [sia_pkg::GAS_W-1:0]           gas_level;
   logic [sia_pkg::BATT_W-1:0]          battery_mv;
   logic [sia_pkg::AGE_W-1:0]           heartbeat_age_ms;
   logic [sia_pkg::CUR_W-1:0]           motor_current_a;
   logic [sia_pkg::CUR_W-1:0]           motor_current_b;
   logic signed [sia_pkg::ANGLE_W-1:0]  pitch;
   logic signed [sia_pkg::ANGLE_W-1:0]  roll;
   logic [sia_pkg::SLOT_W-1:0]          slot_index;

   modport source (output valid, kind, front_distance, rear_distance, gas_level, battery_mv,
                   heartbeat_age_ms, motor_current_a, motor_current_b, pitch, roll,
                   slot_index, input ready);
   modport sink (input valid, kind, front_distance, rear_distance, gas_level, battery_mv,
                 heartbeat_age_ms, motor_current_a, motor_current_b, pitch, roll,
                 slot_index, output ready);
endinterface

interface sia_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            check_passed;
   logic                            safe_to_run;
   logic                            stop_latched;
   logic [sia_pkg::ACTIVE_W-1:0]    active_alerts;
   logic [sia_pkg::TOTAL_W-1:0]     total_alerts;
   logic                            slot_valid;
   logic [sia_pkg::TYPE_W-1:0]      slot_type;
   logic [sia_pkg::LEVEL_W-1:0]     slot_level;

   modport source (output valid, check_passed, safe_to_run, stop_latched, active_alerts,
                   total_alerts, slot_valid, slot_type, slot_level, input ready);
   modport sink (input valid, check_passed, safe_to_run, stop_latched, active_alerts,
                 total_alerts, slot_valid, slot_type, slot_level, output ready);
endinterface

interface sia_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sia_pkg::CSR_IDX_W-1:0]   index;
   logic [sia_pkg::CSR_DAT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/safety_interlock_alert_table_core.sv @@
// Safety interlock core: threshold checks, ordered alert table, stop latch.
// Depends on sia_pkg and the channel interfaces in sia_if.sv.
`timescale 1ns / 1ps

// A request word is taken only while the core is idle; its response word is
// held in an output register, so the next request may enter while the
// previous response still waits. Housekeeping words (reset stop, clear,
// slot read, unused kinds) go straight from the judge state to the done state
// with no table search. A check scans the alert table one entry per cycle to
// find its type and, when a passing check removes an entry, moves each later
// entry down one slot per cycle. Register writes are always taken at once and
// belong only in idle periods. A full table drops a new alert without
// counting it; a critical fault still sets the stop latch.
module safety_interlock_alert_table_core #(
   parameter int ALERT_SLOTS = sia_pkg::ALERT_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sia_req_if.sink   req_bus,
   sia_rsp_if.source rsp_bus,
   sia_csr_if.sink   csr_bus
);

   localparam int CNT_W = $clog2(ALERT_SLOTS + 1);
   localparam int IDX_W = $clog2(ALERT_SLOTS);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(ALERT_SLOTS);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_JUDGE  = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_APPLY  = 6'b001000,
      ST_SHIFT  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [sia_pkg::DIST_W-1:0]  safe_dist_ff, stop_dist_ff;
   logic [sia_pkg::GAS_W-1:0]   gas_limit_ff;
   logic [sia_pkg::BATT_W-1:0]  batt_low_ff, batt_crit_ff;
   logic [sia_pkg::CUR_W-1:0]   hb_timeout_ff, cur_limit_ff;
   logic [sia_pkg::TILT_W-1:0]  tilt_limit_ff;

   logic [sia_pkg::KIND_W-1:0]          kind_ff;
   logic [sia_pkg::DIST_W-1:0]          front_ff, rear_ff;
   logic [sia_pkg::GAS_W-1:0]           gas_ff;
   logic [sia_pkg::BATT_W-1:0]          batt_ff;
   logic [sia_pkg::AGE_W-1:0]           age_ff;
   logic [sia_pkg::CUR_W-1:0]           cur_a_ff, cur_b_ff;
   logic signed [sia_pkg::ANGLE_W-1:0]  pitch_ff, roll_ff;
   logic [sia_pkg::SLOT_W-1:0]          slot_ff;

   logic [1:0]                   grade_ff, grade_in;
   logic [sia_pkg::TYPE_W-1:0]   typ_ff, typ_in;
   logic [CNT_W-1:0]             ptr_ff, ptr_in;
   logic                         found_ff, found_in;
   logic [sia_pkg::LEVEL_W-1:0]  old_lvl_ff, old_lvl_in;
   logic                         passed_ff, passed_in;

   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             crit_ff, crit_in;
   logic [sia_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                         latch_ff, latch_in;

   logic [sia_pkg::TYPE_W-1:0]   tbl_type_ff [ALERT_SLOTS];
   logic [sia_pkg::LEVEL_W-1:0]  tbl_lvl_ff [ALERT_SLOTS];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_passed_ff, rsp_safe_ff, rsp_stop_ff, rsp_svalid_ff;
   logic [sia_pkg::ACTIVE_W-1:0] rsp_active_ff;
   logic [sia_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic [sia_pkg::TYPE_W-1:0]   rsp_stype_ff;
   logic [sia_pkg::LEVEL_W-1:0]  rsp_slevel_ff;
   logic                         rsp_load;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [sia_pkg::TYPE_W-1:0]   wr_type;
   logic [sia_pkg::LEVEL_W-1:0]  wr_lvl;
   logic [IDX_W-1:0]             rd_idx;
   logic [sia_pkg::TYPE_W-1:0]   rd_type;
   logic [sia_pkg::LEVEL_W-1:0]  rd_lvl;

   logic [1:0]                   front_grade, rear_grade;
   logic [sia_pkg::GAS_W:0]      gas_crit;
   logic [sia_pkg::ANGLE_W-1:0]  pitch_abs, roll_abs;
   logic [sia_pkg::ANGLE_W-1:0]  tilt_ext;
   logic [CNT_W-1:0]             ptr_next;
   logic [CNT_W-1:0]             slot_cnt;
   logic                         slot_hit;
   logic [sia_pkg::LEVEL_W-1:0]  new_lvl;
   logic [CNT_W-1:0]             new_crit;
   logic [CNT_W-1:0]             old_crit;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   // threshold judgement
   always_comb begin
      priority if (front_ff != '0 && front_ff < stop_dist_ff) begin
         front_grade = sia_pkg::GRADE_CRITICAL;
      end else if (front_ff != '0 && front_ff < safe_dist_ff) begin
         front_grade = sia_pkg::GRADE_WARNING;
      end else begin
         front_grade = sia_pkg::GRADE_PASS;
      end
      priority if (rear_ff != '0 && rear_ff < stop_dist_ff) begin
         rear_grade = sia_pkg::GRADE_CRITICAL;
      end else if (rear_ff != '0 && rear_ff < safe_dist_ff) begin
         rear_grade = sia_pkg::GRADE_WARNING;
      end else begin
         rear_grade = sia_pkg::GRADE_PASS;
      end
   end

   assign gas_crit  = {1'b0, gas_limit_ff} + sia_pkg::GAS_CRIT_MARGIN;
   assign pitch_abs = pitch_ff[sia_pkg::ANGLE_W-1] ? sia_pkg::ANGLE_W'(-pitch_ff) : pitch_ff;
   assign roll_abs  = roll_ff[sia_pkg::ANGLE_W-1] ? sia_pkg::ANGLE_W'(-roll_ff) : roll_ff;
   assign tilt_ext  = sia_pkg::ANGLE_W'(tilt_limit_ff);

   assign ptr_next = ptr_ff + ONE_CNT;
   assign slot_cnt = CNT_W'(slot_ff);
   assign slot_hit = (kind_ff == sia_pkg::KIND_READ_SLOT) && (slot_cnt < count_ff);
   assign new_lvl  = (grade_ff == sia_pkg::GRADE_CRITICAL) ? sia_pkg::LVL_CRITICAL
                                                           : sia_pkg::LVL_WARNING;
   assign new_crit = (new_lvl == sia_pkg::LVL_CRITICAL) ? ONE_CNT : '0;
   assign old_crit = (old_lvl_ff == sia_pkg::LVL_CRITICAL) ? ONE_CNT : '0;

   always_comb begin
      unique case (state_ff)
         ST_SHIFT: rd_idx = ptr_next[IDX_W-1:0];
         ST_DONE:  rd_idx = IDX_W'(slot_ff);
         default:  rd_idx = ptr_ff[IDX_W-1:0];
      endcase
   end

   assign rd_type = tbl_type_ff[rd_idx];
   assign rd_lvl  = tbl_lvl_ff[rd_idx];

   always_comb begin
      state_in     = state_ff;
      grade_in     = grade_ff;
      typ_in       = typ_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      old_lvl_in   = old_lvl_ff;
      passed_in    = passed_ff;
      count_in     = count_ff;
      crit_in      = crit_ff;
      total_in     = total_ff;
      latch_in     = latch_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = ptr_ff[IDX_W-1:0];
      wr_type      = typ_ff;
      wr_lvl       = new_lvl;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            ptr_in    = '0;
            found_in  = 1'b0;
            passed_in = 1'b0;
            state_in  = ST_SEARCH;
            unique case (kind_ff)
               sia_pkg::KIND_COLLISION: begin
                  typ_in   = sia_pkg::TYPE_COLLISION;
                  grade_in = (front_grade != sia_pkg::GRADE_PASS) ? front_grade : rear_grade;
               end
               sia_pkg::KIND_GAS: begin
                  typ_in = sia_pkg::TYPE_GAS;
                  priority if ({1'b0, gas_ff} > gas_crit) begin
                     grade_in = sia_pkg::GRADE_CRITICAL;
                  end else if (gas_ff > gas_limit_ff) begin
                     grade_in = sia_pkg::GRADE_WARNING;
                  end else begin
                     grade_in = sia_pkg::GRADE_PASS;
                  end
               end
               sia_pkg::KIND_BATTERY: begin
                  typ_in = sia_pkg::TYPE_BATTERY;
                  priority if (batt_ff < batt_crit_ff) begin
                     grade_in = sia_pkg::GRADE_CRITICAL;
                  end else if (batt_ff < batt_low_ff) begin
                     grade_in = sia_pkg::GRADE_WARNING;
                  end else begin
                     grade_in = sia_pkg::GRADE_PASS;
                  end
               end
               sia_pkg::KIND_HEARTBEAT: begin
                  typ_in   = sia_pkg::TYPE_LINK;
                  grade_in = (age_ff > sia_pkg::AGE_W'(hb_timeout_ff)) ?
                             sia_pkg::GRADE_CRITICAL : sia_pkg::GRADE_PASS;
               end
               sia_pkg::KIND_MOTOR: begin
                  typ_in   = sia_pkg::TYPE_OVERCURRENT;
                  grade_in = (cur_a_ff > cur_limit_ff || cur_b_ff > cur_limit_ff) ?
                             sia_pkg::GRADE_WARNING : sia_pkg::GRADE_PASS;
               end
               sia_pkg::KIND_TILT: begin
                  typ_in   = sia_pkg::TYPE_TILT;
                  grade_in = (pitch_abs > tilt_ext || roll_abs > tilt_ext) ?
                             sia_pkg::GRADE_CRITICAL : sia_pkg::GRADE_PASS;
               end
               sia_pkg::KIND_RESET_STOP: begin
                  latch_in = 1'b0;
                  state_in = ST_DONE;
               end
               sia_pkg::KIND_CLEAR: begin
                  count_in = '0;
                  crit_in  = '0;
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SEARCH: begin
            priority if (ptr_ff >= count_ff) begin
               state_in = ST_APPLY;
            end else if (rd_type == typ_ff) begin
               found_in   = 1'b1;
               old_lvl_in = rd_lvl;
               state_in   = ST_APPLY;
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_APPLY: begin
            state_in = ST_DONE;
            if (grade_ff != sia_pkg::GRADE_PASS) begin
               if (new_lvl == sia_pkg::LVL_CRITICAL) begin
                  latch_in = 1'b1;
               end
               priority if (found_ff) begin
                  wr_en   = 1'b1;
                  crit_in = crit_ff - old_crit + new_crit;
               end else if (count_ff < SLOTS_CNT) begin
                  wr_en    = 1'b1;
                  wr_idx   = count_ff[IDX_W-1:0];
                  count_in = count_ff + ONE_CNT;
                  crit_in  = crit_ff + new_crit;
                  if (total_ff != '1) begin
                     total_in = total_ff + 1'b1;
                  end
               end else begin
                  crit_in = crit_ff;
               end
            end else begin
               passed_in = 1'b1;
               if (found_ff) begin
                  crit_in  = crit_ff - old_crit;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (ptr_next < count_ff) begin
               wr_en   = 1'b1;
               wr_type = rd_type;
               wr_lvl  = rd_lvl;
               ptr_in  = ptr_next;
            end else begin
               count_in = count_ff - ONE_CNT;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         crit_ff       <= '0;
         total_ff      <= '0;
         latch_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         safe_dist_ff  <= sia_pkg::RST_SAFE_DISTANCE;
         stop_dist_ff  <= sia_pkg::RST_STOP_DISTANCE;
         gas_limit_ff  <= sia_pkg::RST_GAS_LIMIT;
         batt_low_ff   <= sia_pkg::RST_BATTERY_LOW;
         batt_crit_ff  <= sia_pkg::RST_BATTERY_CRIT;
         hb_timeout_ff <= sia_pkg::RST_HEARTBEAT;
         tilt_limit_ff <= sia_pkg::RST_TILT_LIMIT;
         cur_limit_ff  <= sia_pkg::RST_CURRENT_LIMIT;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         crit_ff      <= crit_in;
         total_ff     <= total_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               sia_pkg::CSR_SAFE_DISTANCE: safe_dist_ff <= csr_bus.data[sia_pkg::DIST_W-1:0];
               sia_pkg::CSR_STOP_DISTANCE: stop_dist_ff <= csr_bus.data[sia_pkg::DIST_W-1:0];
               sia_pkg::CSR_GAS_LIMIT:     gas_limit_ff <= csr_bus.data[sia_pkg::GAS_W-1:0];
               sia_pkg::CSR_BATTERY_LOW:   batt_low_ff  <= csr_bus.data[sia_pkg::BATT_W-1:0];
               sia_pkg::CSR_BATTERY_CRIT:  batt_crit_ff <= csr_bus.data[sia_pkg::BATT_W-1:0];
               sia_pkg::CSR_HEARTBEAT:     hb_timeout_ff <= csr_bus.data;
               sia_pkg::CSR_TILT_LIMIT:    tilt_limit_ff <= csr_bus.data[sia_pkg::TILT_W-1:0];
               sia_pkg::CSR_CURRENT_LIMIT: cur_limit_ff <= csr_bus.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      grade_ff   <= grade_in;
      typ_ff     <= typ_in;
      ptr_ff     <= ptr_in;
      found_ff   <= found_in;
      old_lvl_ff <= old_lvl_in;
      passed_ff  <= passed_in;
      if (state_ff == ST_IDLE && req_bus.valid) begin
         kind_ff  <= req_bus.kind;
         front_ff <= req_bus.front_distance;
         rear_ff  <= req_bus.rear_distance;
         gas_ff   <= req_bus.gas_level;
         batt_ff  <= req_bus.battery_mv;
         age_ff   <= req_bus.heartbeat_age_ms;
         cur_a_ff <= req_bus.motor_current_a;
         cur_b_ff <= req_bus.motor_current_b;
         pitch_ff <= req_bus.pitch;
         roll_ff  <= req_bus.roll;
         slot_ff  <= req_bus.slot_index;
      end
      if (wr_en) begin
         tbl_type_ff[wr_idx] <= wr_type;
         tbl_lvl_ff[wr_idx]  <= wr_lvl;
      end
      if (rsp_load) begin
         rsp_passed_ff <= passed_ff;
         rsp_safe_ff   <= ~latch_ff && (crit_ff == '0);
         rsp_stop_ff   <= latch_ff;
         rsp_active_ff <= sia_pkg::ACTIVE_W'(count_ff);
         rsp_total_ff  <= total_ff;
         rsp_svalid_ff <= slot_hit;
         rsp_stype_ff  <= slot_hit ? rd_type : '0;
         rsp_slevel_ff <= slot_hit ? rd_lvl : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.check_passed  = rsp_passed_ff;
   assign rsp_bus.safe_to_run   = rsp_safe_ff;
   assign rsp_bus.stop_latched  = rsp_stop_ff;
   assign rsp_bus.active_alerts = rsp_active_ff;
   assign rsp_bus.total_alerts  = rsp_total_ff;
   assign rsp_bus.slot_valid    = rsp_svalid_ff;
   assign rsp_bus.slot_type     = rsp_stype_ff;
   assign rsp_bus.slot_level    = rsp_slevel_ff;

endmodule
